// ===== rtl/core/bads_pkg.sv =====
// Shared types and constants of the box average downscaler.
`default_nettype none
package bads_pkg;
  localparam int CFG_W   = 13;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 32;
  localparam int COORD_W = 12;
  localparam int CFG_A_W = 8;

  localparam logic [CFG_A_W-1:0] REG_SRC_W = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_SRC_H = 8'd1;
  localparam logic [CFG_A_W-1:0] REG_TGT_W = 8'd2;
  localparam logic [CFG_A_W-1:0] REG_TGT_H = 8'd3;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_CS_MUL,
    ST_CS_GO,
    ST_CS_WAIT,
    ST_CNT,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_OUT,
    ST_ADV,
    ST_CB_MUL,
    ST_CB_GO,
    ST_CB_WAIT,
    ST_RB_MUL,
    ST_RB_GO,
    ST_RB_WAIT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/bads_sum_ram.sv =====
// Synchronous column sum memory with one write and one registered read port.
`default_nettype none
module bads_sum_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 128
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bads_div.sv =====
// Restoring unsigned divider producing one quotient bit per cycle.
`default_nettype none
module bads_div #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic      [W-1:0] quot
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  assign shifted = {rem_r, q_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};
  assign done    = done_r;
  assign quot    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      q_r   <= {q_r[W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/box_average_image_downscale_core.sv =====
// Top level of the box average downscaler: configuration, sequencer and output register.
// Pixels arrive in raster order and are summed per target column in an on-chip memory.
// A pixel that closes no bin passes through accept with memory read, write back and
// counter update; a pixel that moves to a new column bin adds one pass of the bit-serial
// divider and a new row bin adds a second one. A pixel that closes a bin adds one divider
// pass for the bin start, a step for the bin's pixel count, one divider pass for each
// channel average and the output stage, where it waits while an earlier result is still held.
// After reset and after every configuration write the sum memory is cleared over all
// MAX_WIDTH entries, followed by two boundary divisions, during which no pixel is accepted.
`default_nettype none
module box_average_image_downscale_core
  import bads_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int CHANNELS   = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // chan0, chan1, chan2, chan3
  input  wire logic [31:0]        in_tdata,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // avg0, avg1, avg2, avg3, out_col, out_row
  output logic [55:0]             out_tdata,
  output logic                    out_tlast,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]   cfg_data
);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int SW    = CHANNELS * SUM_W;
  localparam int M1    = (WW > HW) ? WW : HW;
  localparam int D0    = 2 * M1 + 1;
  localparam int DIV_W = (D0 > SUM_W) ? D0 : SUM_W;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [CFG_W-1:0] tgt_w_r, tgt_w_nxt, tgt_h_r, tgt_h_nxt;
  logic [WW-1:0]    src_col_r, src_col_nxt, bin_col_r, bin_col_nxt;
  logic [WW-1:0]    col_bnd_r, col_bnd_nxt, col_start_r, col_start_nxt;
  logic [HW-1:0]    src_row_r, src_row_nxt, bin_row_r, bin_row_nxt;
  logic [HW-1:0]    row_bnd_r, row_bnd_nxt, row_start_r, row_start_nxt;
  logic             need_rb_r, need_rb_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [31:0]      pix_r, pix_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [DIV_W-1:0] mul_r, mul_nxt, cnt_r, cnt_nxt;
  logic [PIX_W-1:0] avg_r [CHANNELS];
  logic [PIX_W-1:0] avg_nxt [CHANNELS];
  logic             out_valid_r, out_valid_nxt;
  logic [55:0]      out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [WW-1:0]    sw_eff, tw_eff;
  logic [HW-1:0]    sh_eff, th_eff;
  logic             last_col, last_row, wrap_col, wrap_row, emit;
  logic [AW-1:0]    col_addr;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [SW-1:0]    ram_wdata, ram_rdata, sum_add;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_den, div_quot, cnt_prod;
  logic [31:0]      avg_all;
  logic             cfg_hit;

  bads_sum_ram #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(SW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (col_addr),
    .rdata (ram_rdata)
  );

  bads_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    if (src_w_r == '0) begin
      sw_eff = WW'(1);
    end else if (32'(src_w_r) > 32'(MAX_WIDTH)) begin
      sw_eff = WW'(MAX_WIDTH);
    end else begin
      sw_eff = WW'(src_w_r);
    end
    if (src_h_r == '0) begin
      sh_eff = HW'(1);
    end else if (32'(src_h_r) > 32'(MAX_HEIGHT)) begin
      sh_eff = HW'(MAX_HEIGHT);
    end else begin
      sh_eff = HW'(src_h_r);
    end
    if (tgt_w_r == '0) begin
      tw_eff = WW'(1);
    end else if (32'(tgt_w_r) > 32'(sw_eff)) begin
      tw_eff = sw_eff;
    end else begin
      tw_eff = WW'(tgt_w_r);
    end
    if (tgt_h_r == '0) begin
      th_eff = HW'(1);
    end else if (32'(tgt_h_r) > 32'(sh_eff)) begin
      th_eff = sh_eff;
    end else begin
      th_eff = HW'(tgt_h_r);
    end
  end

  assign last_col = ({1'b0, src_col_r} + 1'b1) == {1'b0, col_bnd_r};
  assign last_row = ({1'b0, src_row_r} + 1'b1) == {1'b0, row_bnd_r};
  assign wrap_col = ({1'b0, src_col_r} + 1'b1) >= {1'b0, sw_eff};
  assign wrap_row = ({1'b0, src_row_r} + 1'b1) >= {1'b0, sh_eff};
  assign emit     = last_col && last_row;
  assign col_addr = (32'(bin_col_r) < 32'(MAX_WIDTH)) ? AW'(bin_col_r) : AW'(MAX_WIDTH - 1);
  assign cnt_prod = DIV_W'(col_bnd_r - col_start_r) * DIV_W'(row_bnd_r - row_start_r);
  assign cfg_hit  = cfg_valid && (cfg_addr == REG_SRC_W || cfg_addr == REG_SRC_H ||
                                  cfg_addr == REG_TGT_W || cfg_addr == REG_TGT_H);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum_add[c*SUM_W +: SUM_W] = ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(pix_r[c*PIX_W +: PIX_W]);
    end
    avg_all = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      avg_all[c*PIX_W +: PIX_W] = avg_r[c];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    src_w_nxt     = src_w_r;
    src_h_nxt     = src_h_r;
    tgt_w_nxt     = tgt_w_r;
    tgt_h_nxt     = tgt_h_r;
    src_col_nxt   = src_col_r;
    src_row_nxt   = src_row_r;
    bin_col_nxt   = bin_col_r;
    bin_row_nxt   = bin_row_r;
    col_bnd_nxt   = col_bnd_r;
    row_bnd_nxt   = row_bnd_r;
    col_start_nxt = col_start_r;
    row_start_nxt = row_start_r;
    need_rb_nxt   = need_rb_r;
    clr_addr_nxt  = clr_addr_r;
    ch_nxt        = ch_r;
    pix_nxt       = pix_r;
    sum_nxt       = sum_r;
    mul_nxt       = mul_r;
    cnt_nxt       = cnt_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = col_addr;
    ram_wdata     = '0;
    div_start     = 1'b0;
    div_num       = mul_r;
    div_den       = DIV_W'(tw_eff);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
          state_nxt = ST_CB_MUL;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          pix_nxt   = in_tdata;
          ram_re    = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_we  = 1'b1;
        sum_nxt = sum_add;
        if (emit) begin
          state_nxt = ST_CS_MUL;
        end else begin
          ram_wdata = sum_add;
          state_nxt = ST_ADV;
        end
      end
      ST_CS_MUL: begin
        mul_nxt   = DIV_W'(bin_col_r) * DIV_W'(sw_eff);
        state_nxt = ST_CS_GO;
      end
      ST_CS_GO: begin
        div_start = 1'b1;
        state_nxt = ST_CS_WAIT;
      end
      ST_CS_WAIT: begin
        if (div_done) begin
          col_start_nxt = WW'(div_quot);
          state_nxt     = ST_CNT;
        end
      end
      ST_CNT: begin
        cnt_nxt   = (cnt_prod == '0) ? DIV_W'(1) : cnt_prod;
        ch_nxt    = '0;
        state_nxt = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(sum_r[ch_r*SUM_W +: SUM_W]);
        div_den   = cnt_r;
        state_nxt = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        div_num = DIV_W'(sum_r[ch_r*SUM_W +: SUM_W]);
        div_den = cnt_r;
        if (div_done) begin
          avg_nxt[ch_r] = div_quot[PIX_W-1:0];
          if (ch_r == CH_W'(CHANNELS - 1)) begin
            state_nxt = ST_OUT;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_AVG_GO;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {COORD_W'(bin_row_r), COORD_W'(bin_col_r), avg_all};
          out_last_nxt  = ({1'b0, bin_col_r} + 1'b1 == {1'b0, tw_eff}) &&
                          ({1'b0, bin_row_r} + 1'b1 == {1'b0, th_eff});
          state_nxt     = ST_ADV;
        end
      end
      ST_ADV: begin
        src_col_nxt = src_col_r + 1'b1;
        if (last_col) begin
          bin_col_nxt = bin_col_r + 1'b1;
        end
        if (wrap_col) begin
          src_col_nxt = '0;
          bin_col_nxt = '0;
          src_row_nxt = src_row_r + 1'b1;
          if (last_row) begin
            bin_row_nxt   = bin_row_r + 1'b1;
            row_start_nxt = src_row_r + 1'b1;
          end
          if (wrap_row) begin
            src_row_nxt   = '0;
            bin_row_nxt   = '0;
            row_start_nxt = '0;
          end
        end
        need_rb_nxt = wrap_col && (last_row || wrap_row);
        if (last_col || wrap_col) begin
          state_nxt = ST_CB_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CB_MUL: begin
        mul_nxt   = (DIV_W'(bin_col_r) + 1'b1) * DIV_W'(sw_eff);
        state_nxt = ST_CB_GO;
      end
      ST_CB_GO: begin
        div_start = 1'b1;
        state_nxt = ST_CB_WAIT;
      end
      ST_CB_WAIT: begin
        if (div_done) begin
          col_bnd_nxt = WW'(div_quot);
          state_nxt   = need_rb_r ? ST_RB_MUL : ST_IDLE;
        end
      end
      ST_RB_MUL: begin
        mul_nxt   = (DIV_W'(bin_row_r) + 1'b1) * DIV_W'(sh_eff);
        state_nxt = ST_RB_GO;
      end
      ST_RB_GO: begin
        div_start = 1'b1;
        div_den   = DIV_W'(th_eff);
        state_nxt = ST_RB_WAIT;
      end
      ST_RB_WAIT: begin
        div_den = DIV_W'(th_eff);
        if (div_done) begin
          row_bnd_nxt = HW'(div_quot);
          need_rb_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_hit) begin
      unique case (cfg_addr)
        REG_SRC_W: src_w_nxt = cfg_data;
        REG_SRC_H: src_h_nxt = cfg_data;
        REG_TGT_W: tgt_w_nxt = cfg_data;
        default:   tgt_h_nxt = cfg_data;
      endcase
      src_col_nxt   = '0;
      src_row_nxt   = '0;
      bin_col_nxt   = '0;
      bin_row_nxt   = '0;
      row_start_nxt = '0;
      need_rb_nxt   = 1'b1;
      clr_addr_nxt  = '0;
      state_nxt     = ST_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      src_w_r     <= CFG_W'(1);
      src_h_r     <= CFG_W'(1);
      tgt_w_r     <= CFG_W'(1);
      tgt_h_r     <= CFG_W'(1);
      src_col_r   <= '0;
      src_row_r   <= '0;
      bin_col_r   <= '0;
      bin_row_r   <= '0;
      col_bnd_r   <= '0;
      row_bnd_r   <= '0;
      col_start_r <= '0;
      row_start_r <= '0;
      need_rb_r   <= 1'b1;
      clr_addr_r  <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      tgt_w_r     <= tgt_w_nxt;
      tgt_h_r     <= tgt_h_nxt;
      src_col_r   <= src_col_nxt;
      src_row_r   <= src_row_nxt;
      bin_col_r   <= bin_col_nxt;
      bin_row_r   <= bin_row_nxt;
      col_bnd_r   <= col_bnd_nxt;
      row_bnd_r   <= row_bnd_nxt;
      col_start_r <= col_start_nxt;
      row_start_r <= row_start_nxt;
      need_rb_r   <= need_rb_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    sum_r      <= sum_nxt;
    mul_r      <= mul_nxt;
    cnt_r      <= cnt_nxt;
    avg_r      <= avg_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end
endmodule
`default_nettype wire
